>>> hdl/lqs_pkg.sv
// Package for the linear queue with search: sizes, codes and transfer types.
`timescale 1ns / 1ps

package lqs_pkg;

  localparam int DEPTH = 16;
  localparam int IDXW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);
  localparam int SUMW  = (CNTW > 4) ? CNTW : 4;

  typedef enum logic [1:0] {
    KIND_ENQ    = 2'd0,
    KIND_DEQ    = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_ENQUEUED = 3'd0,
    ST_FULL     = 3'd1,
    ST_DEQUEUED = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FOUND    = 3'd4,
    ST_NOTFOUND = 3'd5
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] data_out;
    logic [3:0]         found_slot;
  } out_item_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_WRITE  = 2'd1,
    CELL_ROTATE = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [IDXW-1:0]    pos;
    logic signed [31:0] wdata;
  } cell_ctrl_t;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_SEARCH = 1'b1
  } state_t;

endpackage

>>> hdl/lqs_cell.sv
// One storage cell of the queue chain.
`timescale 1ns / 1ps

module lqs_cell (
  input  logic                     clk,
  input  lqs_pkg::cell_ctrl_t      ctrl,
  input  logic [lqs_pkg::IDXW-1:0] my_idx,
  input  logic signed [31:0]       next_data,
  input  logic signed [31:0]       head_data,
  output logic signed [31:0]       data_q
);
  import lqs_pkg::*;

  logic signed [31:0] data_r;
  logic signed [31:0] data_nxt;

  // A rotate moves every entry one cell toward the head; the cell at the
  // tail position takes the old head, which also serves a plain dequeue.
  always_comb begin
    data_nxt = data_r;
    case (ctrl.op)
      CELL_WRITE: begin
        if (my_idx == ctrl.pos) data_nxt = ctrl.wdata;
      end
      CELL_ROTATE: begin
        data_nxt = (my_idx == ctrl.pos) ? head_data : next_data;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

>>> hdl/lqs_ctrl.sv
// Queue control: pointers, search sequencer and output register.
`timescale 1ns / 1ps

module lqs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lqs_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lqs_pkg::out_item_t   out_data,
  input  logic signed [31:0]   head_data,
  output lqs_pkg::cell_ctrl_t  cell_ctrl
);
  import lqs_pkg::*;

  state_t             state_r, state_nxt;
  logic [CNTW-1:0]    base_r, base_nxt;
  logic [CNTW-1:0]    cnt_r, cnt_nxt;
  logic [CNTW-1:0]    rot_r, rot_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic               found_r, found_nxt;
  logic [3:0]         slot_r, slot_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  logic               accept;
  logic               load;
  logic               hit;
  logic [CNTW-1:0]    cnt_m1;
  logic [CNTW:0]      fill_sum;
  logic [SUMW-1:0]    abs_sum;
  logic [3:0]         slot_now;

  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign cnt_m1   = cnt_r - 1'b1;
  assign fill_sum = {1'b0, base_r} + {1'b0, cnt_r};
  assign abs_sum  = SUMW'(base_r) + SUMW'(rot_r);
  assign slot_now = abs_sum[3:0];
  assign hit      = (head_data == key_r) && !found_r;

  always_comb begin
    state_nxt       = state_r;
    base_nxt        = base_r;
    cnt_nxt         = cnt_r;
    rot_nxt         = rot_r;
    key_nxt         = key_r;
    found_nxt       = found_r;
    slot_nxt        = slot_r;
    load            = 1'b0;
    out_nxt         = out_r;
    cell_ctrl.op    = CELL_HOLD;
    cell_ctrl.pos   = cnt_m1[IDXW-1:0];
    cell_ctrl.wdata = in_data.value;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_data.kind)
            KIND_ENQ: begin
              load = 1'b1;
              out_nxt = '{status: ST_ENQUEUED, data_out: '0, found_slot: '0};
              if (fill_sum == (CNTW+1)'(DEPTH)) begin
                out_nxt.status = ST_FULL;
              end else begin
                cell_ctrl.op  = CELL_WRITE;
                cell_ctrl.pos = cnt_r[IDXW-1:0];
                cnt_nxt       = cnt_r + 1'b1;
              end
            end
            KIND_DEQ: begin
              load = 1'b1;
              out_nxt = '{status: ST_EMPTY, data_out: '0, found_slot: '0};
              if (cnt_r != '0) begin
                out_nxt.status   = ST_DEQUEUED;
                out_nxt.data_out = head_data;
                cell_ctrl.op     = CELL_ROTATE;
                // The last entry leaving returns both pointers to empty.
                if (cnt_r == CNTW'(1)) begin
                  base_nxt = '0;
                  cnt_nxt  = '0;
                end else begin
                  base_nxt = base_r + 1'b1;
                  cnt_nxt  = cnt_m1;
                end
              end
            end
            KIND_SEARCH: begin
              if (cnt_r == '0) begin
                load = 1'b1;
                out_nxt = '{status: ST_NOTFOUND, data_out: '0, found_slot: '0};
              end else begin
                key_nxt   = in_data.value;
                rot_nxt   = '0;
                found_nxt = 1'b0;
                state_nxt = S_SEARCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SEARCH: begin
        // The queue turns once past the head comparator, so it ends in its
        // original order.
        cell_ctrl.op = CELL_ROTATE;
        rot_nxt      = rot_r + 1'b1;
        if (hit) begin
          found_nxt = 1'b1;
          slot_nxt  = slot_now;
        end
        if (rot_r == cnt_m1) begin
          load      = 1'b1;
          state_nxt = S_IDLE;
          out_nxt   = '{status: ST_NOTFOUND, data_out: '0, found_slot: '0};
          if (found_r) begin
            out_nxt.status     = ST_FOUND;
            out_nxt.found_slot = slot_r;
          end else if (hit) begin
            out_nxt.status     = ST_FOUND;
            out_nxt.found_slot = slot_now;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      cnt_r       <= '0;
      rot_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      cnt_r       <= cnt_nxt;
      rot_r       <= rot_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    slot_r <= slot_nxt;
    if (load) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> hdl/linear_queue_with_search.sv
// Top level of the linear queue with search: control plus the cell chain.
`timescale 1ns / 1ps

// Usage:
//   Requests arrive on the in_ channel (valid/stall) as {kind, value}:
//   enqueue, dequeue or search. Kind three is taken and dropped silently.
//   Each other request yields one result on the out_ channel as
//   {status, data_out, found_slot}, held in an output register.
//   For enqueue and dequeue the result is valid the cycle after the transfer,
//   and the next request may follow at once unless a result waits under out_stall.
//   A search on a queue holding N entries turns the entries once through the
//   chain after the transfer, past the comparator at the head cell, one entry
//   per cycle, so the cost is set by the queue fill.
//   On an empty queue the search result is valid the cycle after the transfer.
//   in_stall is high for the whole turn.
//   A result waiting under out_stall blocks only the next request; the
//   request is taken in the cycle the waiting result transfers.
//   Reset empties the queue and drops any pending result. No clearing pass
//   is needed: slot contents are never read before they are written.
module linear_queue_with_search (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lqs_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lqs_pkg::out_item_t  out_data
);
  import lqs_pkg::*;

  cell_ctrl_t         cell_ctrl;
  logic signed [31:0] cell_data [DEPTH];

  lqs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .head_data (cell_data[0]),
    .cell_ctrl (cell_ctrl)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] next_data;

    if (i == DEPTH - 1) begin : g_tail
      assign next_data = cell_data[0];
    end else begin : g_mid
      assign next_data = cell_data[i+1];
    end

    lqs_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .my_idx    (IDXW'(i)),
      .next_data (next_data),
      .head_data (cell_data[0]),
      .data_q    (cell_data[i])
    );
  end

endmodule

>>> tb/linear_queue_with_search_tb.sv
// Self-checking testbench for the linear queue with search: directed and random requests.
`timescale 1ns / 1ps

module linear_queue_with_search_tb;
  import lqs_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  linear_queue_with_search u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the queue contents and pointers.
  logic signed [31:0] model_slots [DEPTH];
  int                 model_front = -1;
  int                 model_rear = -1;
  out_item_t          expected_results [$];

  int  requests_sent = 0;
  int  results_checked = 0;
  int  full_seen = 0;
  int  found_seen = 0;
  int  empty_seen = 0;
  int  fault_count = 0;
  bit  quiet = 1'b0;
  int  hold_req = 0;
  int  hold_left = 0;
  int  burst_left = 0;

  // Work out the result of one accepted request and update the shadow queue.
  task automatic predict_request(input in_item_t req);
    out_item_t res;
    res = '{status: ST_NOTFOUND, data_out: '0, found_slot: '0};
    case (req.kind)
      KIND_ENQ: begin
        if (model_rear >= DEPTH - 1) begin
          res.status = ST_FULL;
        end else begin
          model_rear++;
          model_slots[model_rear] = req.value;
          res.status = ST_ENQUEUED;
        end
      end
      KIND_DEQ: begin
        if (model_rear >= 0 && model_front < model_rear) begin
          model_front++;
          res.status = ST_DEQUEUED;
          res.data_out = model_slots[model_front];
        end else begin
          res.status = ST_EMPTY;
        end
        // Freed slots are only reused once the queue has fully drained.
        if (model_front == model_rear) begin
          model_front = -1;
          model_rear = -1;
        end
      end
      KIND_SEARCH: begin
        for (int i = model_front + 1; i <= model_rear; i++) begin
          if (model_slots[i] == req.value) begin
            res.status = ST_FOUND;
            res.found_slot = 4'(i);
            break;
          end
        end
      end
      KIND_NONE: return;
    endcase
    expected_results.push_back(res);
  endtask

  // Offer one request and hold it until the transfer happens.
  task automatic send_request(input kind_t k, input logic signed [31:0] v);
    in_item_t req;
    int       gap;
    req = '{kind: k, value: v};
    gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_request(req);
    if (k != KIND_NONE) requests_sent++;
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2, 3: return 32'($urandom_range(0, 7)) - 32'd4;
      default: return $urandom;
    endcase
  endfunction

  // Mostly search for something held in the queue, sometimes one bit off it.
  function automatic logic signed [31:0] pick_search_value();
    logic signed [31:0] v;
    if (model_rear >= 0 && $urandom_range(0, 3) != 0) begin
      v = model_slots[$urandom_range(model_front + 1, model_rear)];
      if ($urandom_range(0, 3) == 0) v = v ^ (32'sd1 << $urandom_range(0, 31));
      return v;
    end
    return pick_value();
  endfunction

  task automatic send_random(input int enq_pct, input int deq_pct);
    int r;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 39) == 0) send_request(KIND_NONE, $urandom);
    else if (r < enq_pct) send_request(KIND_ENQ, pick_value());
    else if (r < enq_pct + deq_pct) send_request(KIND_DEQ, $urandom);
    else send_request(KIND_SEARCH, pick_search_value());
  endtask

  task automatic report_fault(input string what, input logic [31:0] want,
                              input logic [31:0] got);
    fault_count++;
    if (fault_count <= 10)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
  endtask

  // Result checker.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_results.size() == 0) begin
        report_fault("unexpected result", '0, out_data.data_out);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_data.status !== want.status)
          report_fault("status", 32'(want.status), 32'(out_data.status));
        if (out_data.data_out !== want.data_out)
          report_fault("data_out", want.data_out, out_data.data_out);
        if (out_data.found_slot !== want.found_slot)
          report_fault("found_slot", 32'(want.found_slot), 32'(out_data.found_slot));
        case (want.status)
          ST_FULL:  full_seen++;
          ST_FOUND: found_seen++;
          ST_EMPTY: empty_seen++;
          default: ;
        endcase
      end
    end
  end

  // Receiver stalls: short random bursts, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      burst_left = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic test_empty_queue();
    send_request(KIND_DEQ, 32'sh1234_5678);
    send_request(KIND_SEARCH, 32'sh0000_0000);
    send_request(KIND_NONE, 32'shffff_ffff);
    send_request(KIND_SEARCH, -32'sd1);
  endtask

  // Extreme values, duplicates, and a search after the front has moved.
  task automatic test_value_extremes();
    send_request(KIND_ENQ, 32'sh8000_0000);
    send_request(KIND_ENQ, 32'sh7fff_ffff);
    send_request(KIND_ENQ, 32'sh0000_0000);
    send_request(KIND_ENQ, -32'sd1);
    send_request(KIND_ENQ, 32'sh8000_0000);
    send_request(KIND_SEARCH, 32'sh7fff_ffff);
    send_request(KIND_SEARCH, 32'sh8000_0000);
    send_request(KIND_SEARCH, 32'sh7fff_fffe);
    send_request(KIND_DEQ, '0);
    send_request(KIND_SEARCH, 32'sh8000_0000);
    repeat (5) send_request(KIND_DEQ, '0);
  endtask

  // A freed slot is not reused until the queue drains and the pointers reset.
  task automatic test_full_after_advance();
    repeat (DEPTH) send_request(KIND_ENQ, pick_value());
    send_request(KIND_ENQ, pick_value());
    repeat (2) send_request(KIND_DEQ, '0);
    send_request(KIND_ENQ, pick_value());
    send_request(KIND_SEARCH, model_slots[0]);
    send_request(KIND_SEARCH, model_slots[DEPTH - 1]);
    repeat (DEPTH - 2) send_request(KIND_DEQ, '0);
    send_request(KIND_ENQ, 32'sh5a5a_a5a5);
    send_request(KIND_SEARCH, 32'sh5a5a_a5a5);
    send_request(KIND_DEQ, '0);
  endtask

  task automatic test_input_backpressure();
    hold_req = 80;
    repeat (24) send_random(60, 15);
  endtask

  task automatic test_random_traffic(input int target);
    int style;
    int n;
    while (requests_sent < target) begin
      style = $urandom_range(0, 2);
      n = $urandom_range(10, 40);
      repeat (n) begin
        case (style)
          0: send_random(70, 10);
          1: send_random(15, 60);
          default: send_random(35, 30);
        endcase
      end
    end
  endtask

  task automatic test_quiet_tail();
    quiet = 1'b1;
    repeat (200) send_random(40, 30);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_queue();
    test_value_extremes();
    test_full_after_advance();
    test_input_backpressure();
    test_random_traffic(1550);
    test_quiet_tail();
    in_valid <= 1'b0;
    for (int n = 0; n < 2000 && expected_results.size() != 0; n++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0) begin
      fault_count += expected_results.size();
      $display("%0d expected results never arrived", expected_results.size());
    end
    $display("Sent %0d requests and checked %0d results.", requests_sent, results_checked);
    $display("Outcomes seen: %0d refused as full, %0d matches found, %0d dequeues from empty.",
             full_seen, found_seen, empty_seen);
    if (fault_count == 0) begin
      $display("linear_queue_with_search_tb: clean");
    end else begin
      $display("linear_queue_with_search_tb: errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timed out waiting for transfers.");
    $display("linear_queue_with_search_tb: errors");
    $finish;
  end

endmodule
